### rtl/core/awa_pkg.sv
`timescale 1ns / 1ps

package awa_pkg;

	// widths of the fixed fields
	localparam int TIME_W    = 32;
	localparam int CFG_IDX_W = 1;

	// operation codes
	localparam logic OP_SPEND = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'b1;

	// register reset values
	localparam logic [TIME_W-1:0] BUCKET_LEN_RST = 32'd56250;
	localparam logic [TIME_W-1:0] WINDOW_LEN_RST = 32'd3600000;

	// one command item
	typedef struct packed {
		logic              operation;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] air_ms;
	} awa_cmd_t;

	// one result item
	typedef struct packed {
		logic [TIME_W-1:0] window_sum_ms;
		logic [TIME_W-1:0] total_ms;
		logic [TIME_W-1:0] burst_count;
	} awa_rsp_t;

endpackage

### rtl/core/awa_ram.sv
`timescale 1ns / 1ps

module awa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/airtime_window_accounting.sv
`timescale 1ns / 1ps

// Sliding-window airtime accounting over a ring of BUCKETS time buckets. A command is
// taken when start is high and busy is low; busy then stays high until the result,
// which is shown on result for exactly one cycle with done high and cannot be held off.
// Time arithmetic runs through one shared 33-bit add/subtract unit under a
// small sequencer; the bucket sweep keeps its own window compare and accumulator.
// A query runs the bucket sweep, which reads one ring entry per cycle from the bucket
// RAM. A spend that stays inside the head bucket adds its airtime there and to the
// totals before the same sweep; one that advances the head by k buckets first runs a
// restoring divide and moves the head start, then steps the head one bucket at a time
// when k < BUCKETS, while k >= BUCKETS empties the whole ring at once. Configuration
// writes must be made only while busy is low; the block itself does not enforce this.
// Bucket contents are cleared by per-entry valid bits, so no clearing pass follows
// reset.
module airtime_window_accounting #(
	parameter int BUCKETS = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  awa_pkg::awa_cmd_t                     cmd,
	output logic                                  done,
	output awa_pkg::awa_rsp_t                     result,
	input  logic                                  cfg_we,
	input  logic [awa_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [awa_pkg::TIME_W-1:0]            cfg_wdata
);

	import awa_pkg::*;

	localparam int IW    = $clog2(BUCKETS);
	localparam int CNT_W = (IW > 5) ? IW : 5;

	typedef enum logic [18:0] {
		S_IDLE    = 19'b1 << 0,
		S_DIFF    = 19'b1 << 1,
		S_NEG     = 19'b1 << 2,
		S_GE1     = 19'b1 << 3,
		S_GE2     = 19'b1 << 4,
		S_CMPB    = 19'b1 << 5,
		S_DIV     = 19'b1 << 6,
		S_HS1     = 19'b1 << 7,
		S_HS2     = 19'b1 << 8,
		S_KCMP    = 19'b1 << 9,
		S_ADV     = 19'b1 << 10,
		S_RD      = 19'b1 << 11,
		S_WR      = 19'b1 << 12,
		S_TOT     = 19'b1 << 13,
		S_CNT     = 19'b1 << 14,
		S_SUMINIT = 19'b1 << 15,
		S_SUM     = 19'b1 << 16,
		S_DRAIN   = 19'b1 << 17,
		S_OUT     = 19'b1 << 18
	} awa_state_t;

	awa_state_t        state_q;

	// configuration
	logic [TIME_W-1:0] blen_q;
	logic [TIME_W-1:0] wlen_q;

	// accounting state
	logic              started_q;
	logic [IW-1:0]     head_q;
	logic [TIME_W-1:0] hs_q;
	logic [BUCKETS-1:0] vld_q;
	logic [TIME_W-1:0] total_q;
	logic [TIME_W-1:0] count_q;

	// working registers
	awa_cmd_t          cmd_q;
	logic [TIME_W-1:0] diff_q;
	logic [TIME_W-1:0] aux_q;
	logic              ge_q;
	logic [TIME_W-1:0] r_q;
	logic [TIME_W-1:0] dq_q;
	logic [TIME_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IW-1:0]     at_q;
	logic [TIME_W-1:0] off_q;
	logic [TIME_W-1:0] sum_q;
	logic              v_s1;
	logic              win_s1;

	// shared add/subtract unit
	logic [TIME_W:0]   sh_a;
	logic [TIME_W:0]   sh_b;
	logic              sh_sub;
	logic [TIME_W+1:0] sh_res;
	logic              sh_ge;

	// bucket RAM
	logic              ram_we;
	logic [IW-1:0]     ram_raddr;
	logic [TIME_W-1:0] ram_rdata;
	logic [TIME_W-1:0] old_air;

	logic              accept;
	logic [IW-1:0]     head_inc;
	logic [IW-1:0]     at_dec;

	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign done     = (state_q == S_OUT);
	assign head_inc = (head_q == IW'(BUCKETS - 1)) ? '0 : head_q + 1'b1;
	assign at_dec   = (at_q == '0) ? IW'(BUCKETS - 1) : at_q - 1'b1;
	assign old_air  = vld_q[head_q] ? ram_rdata : '0;

	assign result.window_sum_ms = sum_q;
	assign result.total_ms      = total_q;
	assign result.burst_count   = count_q;

	// a - b sets the top bit when a >= b; a + b leaves the carry there
	assign sh_res = {1'b0, sh_a} + {1'b0, (sh_sub ? ~sh_b : sh_b)} + {{(TIME_W+1){1'b0}}, sh_sub};
	assign sh_ge  = sh_res[TIME_W+1];

	// operand selection for the shared unit
	always_comb begin
		sh_a   = '0;
		sh_b   = '0;
		sh_sub = 1'b0;
		case (state_q)
			S_DIFF, S_SUMINIT: begin
				sh_a   = {1'b0, cmd_q.now_ms};
				sh_b   = {1'b0, hs_q};
				sh_sub = 1'b1;
			end
			S_NEG: begin
				sh_a   = {1'b0, hs_q};
				sh_b   = {1'b0, cmd_q.now_ms};
				sh_sub = 1'b1;
			end
			S_GE1: begin
				sh_a   = {1'b0, diff_q};
				sh_b   = {1'b0, wlen_q};
				sh_sub = 1'b1;
			end
			S_GE2: begin
				sh_a   = {1'b0, aux_q};
				sh_b   = {1'b0, wlen_q};
				sh_sub = 1'b1;
			end
			S_CMPB: begin
				sh_a   = {1'b0, diff_q};
				sh_b   = {1'b0, blen_q};
				sh_sub = 1'b1;
			end
			S_DIV: begin
				sh_a   = {r_q, dq_q[TIME_W-1]};
				sh_b   = {1'b0, dvs_q};
				sh_sub = 1'b1;
			end
			S_HS1: begin
				sh_a   = {1'b0, diff_q};
				sh_b   = {1'b0, r_q};
				sh_sub = 1'b1;
			end
			S_HS2: begin
				sh_a = {1'b0, hs_q};
				sh_b = {1'b0, diff_q};
			end
			S_KCMP: begin
				sh_a   = {1'b0, dq_q};
				sh_b   = (TIME_W + 1)'(BUCKETS);
				sh_sub = 1'b1;
			end
			S_WR: begin
				sh_a = {1'b0, old_air};
				sh_b = {1'b0, cmd_q.air_ms};
			end
			S_TOT: begin
				sh_a = {1'b0, total_q};
				sh_b = {1'b0, cmd_q.air_ms};
			end
			S_CNT: begin
				sh_a = {1'b0, count_q};
				sh_b = (TIME_W + 1)'(1);
			end
			S_SUM: begin
				sh_a = {1'b0, off_q};
				sh_b = {1'b0, blen_q};
			end
			default: begin
				sh_sub = 1'b0;
			end
		endcase
	end

	assign ram_we    = (state_q == S_WR);
	assign ram_raddr = (state_q == S_SUM) ? at_q : head_q;

	awa_ram #(
		.WIDTH(TIME_W),
		.DEPTH(BUCKETS)
	) u_bucket_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head_q),
		.wdata(sh_res[TIME_W-1:0]),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q <= BUCKET_LEN_RST;
			wlen_q <= WINDOW_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BUCKET_LEN: blen_q <= cfg_wdata;
				CFG_WINDOW_LEN: wlen_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// sequencer and accounting state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			started_q <= 1'b0;
			head_q    <= '0;
			hs_q      <= '0;
			vld_q     <= '0;
			total_q   <= '0;
			count_q   <= '0;
			v_s1      <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_SUM);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (cmd.operation == OP_SPEND) ? S_DIFF : S_SUMINIT;
					end
				end
				S_DIFF: begin
					if (!started_q) begin
						started_q <= 1'b1;
						hs_q      <= cmd_q.now_ms;
						state_q   <= S_RD;
					end else begin
						state_q <= S_NEG;
					end
				end
				S_NEG:  state_q <= S_GE1;
				S_GE1:  state_q <= S_GE2;
				S_GE2: begin
					if (ge_q && sh_ge) begin
						// gap in both directions: drop the whole ring
						vld_q   <= '0;
						head_q  <= '0;
						hs_q    <= cmd_q.now_ms;
						state_q <= S_RD;
					end else if (blen_q == '0 || ge_q) begin
						state_q <= S_RD;
					end else begin
						state_q <= S_CMPB;
					end
				end
				S_CMPB: state_q <= sh_ge ? S_DIV : S_RD;
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_HS1;
					end
				end
				S_HS1:  state_q <= S_HS2;
				S_HS2: begin
					hs_q    <= sh_res[TIME_W-1:0];
					state_q <= S_KCMP;
				end
				S_KCMP: begin
					if (sh_ge) begin
						// every bucket is entered: empty the ring, the head position
						// then makes no difference since only offsets from it count
						vld_q   <= '0;
						state_q <= S_RD;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					// step the head one bucket, emptying the bucket entered
					vld_q[head_inc] <= 1'b0;
					head_q          <= head_inc;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_RD;
					end
				end
				S_RD:   state_q <= S_WR;
				S_WR: begin
					vld_q[head_q] <= 1'b1;
					state_q       <= S_TOT;
				end
				S_TOT: begin
					total_q <= sh_res[TIME_W-1:0];
					state_q <= S_CNT;
				end
				S_CNT: begin
					count_q <= sh_res[TIME_W-1:0];
					state_q <= S_SUMINIT;
				end
				S_SUMINIT: state_q <= started_q ? S_SUM : S_OUT;
				S_SUM: begin
					if (cnt_q == '0) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_OUT;
				S_OUT:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (v_s1 && win_s1) begin
			sum_q <= sum_q + ram_rdata;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q <= cmd;
				end
			end
			S_DIFF:  diff_q <= sh_res[TIME_W-1:0];
			S_NEG:   aux_q  <= sh_res[TIME_W-1:0];
			S_GE1:   ge_q   <= sh_ge;
			S_CMPB: begin
				dq_q  <= diff_q;
				r_q   <= '0;
				dvs_q <= blen_q;
				cnt_q <= CNT_W'(TIME_W - 1);
			end
			S_DIV: begin
				// restoring divide, one quotient bit per cycle
				r_q   <= sh_ge ? sh_res[TIME_W-1:0] : {r_q[TIME_W-2:0], dq_q[TIME_W-1]};
				dq_q  <= {dq_q[TIME_W-2:0], sh_ge};
				cnt_q <= cnt_q - 1'b1;
			end
			S_HS1:   diff_q <= sh_res[TIME_W-1:0];
			S_KCMP: begin
				if (!sh_ge) begin
					cnt_q <= dq_q[CNT_W-1:0];
				end
			end
			S_ADV:   cnt_q <= cnt_q - 1'b1;
			S_SUMINIT: begin
				off_q <= sh_res[TIME_W-1:0];
				sum_q <= '0;
				at_q  <= head_q;
				cnt_q <= CNT_W'(BUCKETS - 1);
			end
			S_SUM: begin
				// walk back from the head, start time falling by one bucket per step
				win_s1 <= (off_q < wlen_q) && vld_q[at_q];
				off_q  <= sh_res[TIME_W-1:0];
				at_q   <= at_dec;
				cnt_q  <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/core/awa_checker.sv
`timescale 1ns / 1ps

module awa_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// a command transfer always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after command transfer");

	// a result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// results only come out of a busy block
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done while not busy");

	// work ends only with a result
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

endmodule

bind airtime_window_accounting awa_checker u_awa_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);
